// ===== hw/rtl/c_escape_sequence_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the escape decoder RTL
// Clocked, reset-qualified property checks in two timing forms.
// ----------------------------------------------------------------------------
`ifndef C_ESCAPE_SEQUENCE_DECODER_CORE_DEFINES_SVH
`define C_ESCAPE_SEQUENCE_DECODER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CED_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ced assertion failed");

// next-cycle implication, checked out of reset
`define CED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ced assertion failed");

`endif

// ===== hw/rtl/ced_pkg.sv =====
// ----------------------------------------------------------------------------
// ced_pkg
// Types, codes and character helpers for the C escape sequence decoder.
// ----------------------------------------------------------------------------
package ced_pkg;

	// decoder mode, one-hot
	typedef enum logic [5:0] {
		M_IDLE      = 6'b000001,
		M_ESC       = 6'b000010,
		M_HEX_FIRST = 6'b000100,
		M_HEX       = 6'b001000,
		M_OCT       = 6'b010000,
		M_DROP      = 6'b100000
	} mode_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_UNTERM  = 3'd1,
		ST_NOHEX   = 3'd2,
		ST_HEXBIG  = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_X_LO   = 8'h78;
	localparam logic [7:0] CH_X_UP   = 8'h58;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CASE_BIT  = 8'h20;

	// decoder state
	typedef struct packed {
		mode_t      mode;
		logic [7:0] val;
		logic [1:0] cnt;
		logic       ovf;
	} st_t;

	// one result item
	typedef struct packed {
		logic [7:0] ch;
		status_t    status;
		logic       run_end;
		logic       string_end;
	} res_t;

	// up to two results caused by one input byte
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} res_pair_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	localparam st_t ST_RESET = '{mode: M_IDLE, val: 8'h00, cnt: 2'd0, ovf: 1'b0};

	// hex digit value of a byte, either case
	function automatic digit_t hex_nibble(input logic [7:0] c);
		digit_t     d;
		logic [7:0] lc;
		d  = '{ok: 1'b0, val: 4'd0};
		lc = c | CASE_BIT;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = '{ok: 1'b1, val: c[3:0]};
		end else if (lc >= 8'h61 && lc <= 8'h66) begin
			d = '{ok: 1'b1, val: 4'(lc - 8'h57)};
		end
		return d;
	endfunction

	// byte value of a simple escape letter; ok low when not one
	function automatic logic [8:0] simple_escape(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			8'h61:   r = {1'b1, 8'h07};
			8'h62:   r = {1'b1, 8'h08};
			8'h66:   r = {1'b1, 8'h0c};
			8'h6e:   r = {1'b1, 8'h0a};
			8'h72:   r = {1'b1, 8'h0d};
			8'h74:   r = {1'b1, 8'h09};
			8'h76:   r = {1'b1, 8'h0b};
			8'h5c:   r = {1'b1, 8'h5c};
			8'h27:   r = {1'b1, 8'h27};
			8'h22:   r = {1'b1, 8'h22};
			8'h3f:   r = {1'b1, 8'h3f};
			default: r = {1'b0, 8'h00};
		endcase
		return r;
	endfunction

	function automatic logic is_octal(input logic [7:0] c);
		return c[7:3] == 5'b00110;
	endfunction

	function automatic res_t mk_res(input logic [7:0] ch, input status_t st,
			input logic send);
		return '{ch: ch, status: st, run_end: 1'b0, string_end: send};
	endfunction

endpackage

// ===== hw/rtl/ced_decode.sv =====
// ----------------------------------------------------------------------------
// ced_decode
// Next-state and result logic for one input byte of the escape decoder.
// ----------------------------------------------------------------------------
module ced_decode (
	input  ced_pkg::st_t       st,
	input  logic [7:0]         in_char,
	input  logic               in_final,
	output ced_pkg::st_t       st_nxt,
	output ced_pkg::res_pair_t res
);
	import ced_pkg::*;

	logic       is_bs;
	logic       p_emit;
	res_t       p_res;
	st_t        p_st;
	digit_t     hd;
	logic [8:0] se;
	logic       hovf;
	logic [7:0] hval;
	logic [7:0] oval;
	logic [1:0] ocnt;
	st_t        clr;

	// plain byte handling, reused after a numeric escape ends
	always_comb begin
		is_bs  = in_char == CH_BSLASH;
		p_emit = !(is_bs && !in_final);
		p_res  = is_bs ? mk_res(8'h00, ST_UNTERM, 1'b1) : mk_res(in_char, ST_OK, in_final);
		p_st   = ST_RESET;
		if (is_bs && !in_final) begin
			p_st.mode = M_ESC;
		end
	end

	// digit arithmetic
	always_comb begin
		hd   = hex_nibble(in_char);
		se   = simple_escape(in_char);
		hovf = st.ovf | (st.val > 8'h0f);
		hval = {st.val[3:0], hd.val};
		oval = {st.val[4:0], in_char[2:0]};
		ocnt = st.cnt + 2'd1;
	end

	// mode dispatch
	always_comb begin
		clr    = ST_RESET;
		st_nxt = st;
		res    = '0;
		case (st.mode)
			M_ESC: begin
				if (se[8]) begin
					st_nxt = clr;
					res.v0 = 1'b1;
					res.r0 = mk_res(se[7:0], ST_OK, in_final);
				end else if (in_char == CH_X_LO || in_char == CH_X_UP) begin
					if (in_final) begin
						st_nxt = clr;
						res.v0 = 1'b1;
						res.r0 = mk_res(8'h00, ST_NOHEX, 1'b1);
					end else begin
						st_nxt      = clr;
						st_nxt.mode = M_HEX_FIRST;
					end
				end else if (is_octal(in_char)) begin
					if (in_final) begin
						st_nxt = clr;
						res.v0 = 1'b1;
						res.r0 = mk_res(in_char - CH_ZERO, ST_OK, 1'b1);
					end else begin
						st_nxt      = clr;
						st_nxt.mode = M_OCT;
						st_nxt.val  = in_char - CH_ZERO;
						st_nxt.cnt  = 2'd1;
					end
				end else begin
					st_nxt      = clr;
					st_nxt.mode = in_final ? M_IDLE : M_DROP;
					res.v0      = 1'b1;
					res.r0      = mk_res(8'h00, ST_UNKNOWN, 1'b1);
				end
			end
			M_HEX_FIRST: begin
				if (!hd.ok) begin
					st_nxt      = clr;
					st_nxt.mode = in_final ? M_IDLE : M_DROP;
					res.v0      = 1'b1;
					res.r0      = mk_res(8'h00, ST_NOHEX, 1'b1);
				end else if (in_final) begin
					st_nxt = clr;
					res.v0 = 1'b1;
					res.r0 = mk_res({4'h0, hd.val}, ST_OK, 1'b1);
				end else begin
					st_nxt      = clr;
					st_nxt.mode = M_HEX;
					st_nxt.val  = {4'h0, hd.val};
				end
			end
			M_HEX: begin
				if (hd.ok) begin
					if (in_final) begin
						st_nxt = clr;
						res.v0 = 1'b1;
						res.r0 = hovf ? mk_res(8'h00, ST_HEXBIG, 1'b1)
							: mk_res(hval, ST_OK, 1'b1);
					end else begin
						st_nxt.val = hval;
						st_nxt.ovf = hovf;
					end
				end else if (st.ovf) begin
					st_nxt      = clr;
					st_nxt.mode = in_final ? M_IDLE : M_DROP;
					res.v0      = 1'b1;
					res.r0      = mk_res(8'h00, ST_HEXBIG, 1'b1);
				end else begin
					// release the value, then treat the byte as plain
					st_nxt = p_st;
					res.v0 = 1'b1;
					res.r0 = mk_res(st.val, ST_OK, 1'b0);
					res.v1 = p_emit;
					res.r1 = p_res;
				end
			end
			M_OCT: begin
				if (is_octal(in_char) && st.cnt < 2'd3) begin
					if (ocnt == 2'd3 || in_final) begin
						st_nxt = clr;
						res.v0 = 1'b1;
						res.r0 = mk_res(oval, ST_OK, in_final);
					end else begin
						st_nxt.val = oval;
						st_nxt.cnt = ocnt;
					end
				end else begin
					st_nxt = p_st;
					res.v0 = 1'b1;
					res.r0 = mk_res(st.val, ST_OK, 1'b0);
					res.v1 = p_emit;
					res.r1 = p_res;
				end
			end
			M_DROP: begin
				if (in_final) begin
					st_nxt = clr;
				end
			end
			default: begin
				st_nxt = p_st;
				res.v0 = p_emit;
				res.r0 = p_res;
			end
		endcase
		// mark the last result of this byte
		res.r0.run_end = !res.v1;
		res.r1.run_end = 1'b1;
	end

endmodule

// ===== hw/rtl/ced_outq.sv =====
// ----------------------------------------------------------------------------
// ced_outq
// Three-entry shifting result queue; head entry drives the output port.
// ----------------------------------------------------------------------------
`include "c_escape_sequence_decoder_core_defines.svh"

module ced_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  ced_pkg::res_pair_t push,
	input  logic               pop,
	output ced_pkg::res_t      head,
	output logic               head_valid,
	output logic               almost_full
);
	import ced_pkg::*;

	res_t       ent_q [3];
	res_t       ent_d [3];
	logic [1:0] count_q;
	logic [1:0] base;
	logic [1:0] count_d;

	// shift on transfer, then append new results behind the survivors
	always_comb begin
		base    = count_q - 2'(pop);
		count_d = base + 2'(push.v0) + 2'(push.v1);
		ent_d[0] = pop ? ent_q[1] : ent_q[0];
		ent_d[1] = pop ? ent_q[2] : ent_q[1];
		ent_d[2] = ent_q[2];
		for (int i = 0; i < 3; i++) begin
			if (push.v0 && 2'(i) == base) begin
				ent_d[i] = push.r0;
			end
			if (push.v1 && 2'(i) == base + 2'd1) begin
				ent_d[i] = push.r1;
			end
		end
	end

	// hold payload
	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	// advance occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_d;
		end
	end

	assign head        = ent_q[0];
	assign head_valid  = count_q != 2'd0;
	assign almost_full = count_q[1];

	`CED_ASSERT_SAME(a_no_pop_empty, clk, arst_n, pop, count_q != 2'd0)
	`CED_ASSERT_SAME(a_push_fits, clk, arst_n, push.v0 && push.v1, base <= 2'd1)
	`CED_ASSERT_NEXT(a_drain, clk, arst_n, count_q == 2'd1 && pop && !push.v0,
		count_q == 2'd0)

endmodule

// ===== hw/rtl/c_escape_sequence_decoder_core.sv =====
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_core
// Streaming decoder for C string escapes, one raw byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one raw string byte and its
//   end-of-string flag. Output channel (out_valid / out_stall) carries decoded
//   bytes with status, run_end and string_end.
//   A byte is decoded in the cycle of its transfer against the mode register;
//   its results are written into the registered three-entry output queue,
//   whose head entry drives the output.
//   Throughput is one byte per cycle while in_stall is low. A byte that
//   closes a numeric escape and also produces a byte of its own gives two
//   results; the queue holds them and in_stall is high while they drain.
//   in_stall is high whenever two or more results are queued, so the queue
//   always has room for the two results one byte can cause.
//   A stalled receiver keeps the head result steady; input flow stops once the
//   queue reaches two entries.
//   Reset empties the queue and returns the decoder to idle, expecting a plain
//   byte.
// ----------------------------------------------------------------------------
`include "c_escape_sequence_decoder_core_defines.svh"

module c_escape_sequence_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       in_final,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic [2:0] status,
	output logic       run_end,
	output logic       string_end
);
	import ced_pkg::*;

	st_t       st_q;
	st_t       st_nxt;
	res_pair_t dec_res;
	res_pair_t push;
	res_t      head;
	logic      in_xfer;
	logic      out_xfer;
	logic      almost_full;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign in_stall = almost_full;

	ced_decode u_decode (
		.st       (st_q),
		.in_char  (in_char),
		.in_final (in_final),
		.st_nxt   (st_nxt),
		.res      (dec_res)
	);

	// drop results unless a byte transfers
	always_comb begin
		push    = dec_res;
		push.v0 = dec_res.v0 && in_xfer;
		push.v1 = dec_res.v1 && in_xfer;
	end

	// advance decoder state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (in_xfer) begin
			st_q <= st_nxt;
		end
	end

	ced_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.pop         (out_xfer),
		.head        (head),
		.head_valid  (out_valid),
		.almost_full (almost_full)
	);

	assign out_char   = head.ch;
	assign status     = head.status;
	assign run_end    = head.run_end;
	assign string_end = head.string_end;

	`CED_ASSERT_SAME(a_second_needs_first, clk, arst_n, push.v1, push.v0)
	`CED_ASSERT_SAME(a_drop_silent, clk, arst_n, st_q.mode == M_DROP, !dec_res.v0)
	`CED_ASSERT_SAME(a_err_zero, clk, arst_n, push.v0 && push.r0.status != ST_OK,
		push.r0.ch == 8'h00 && push.r0.string_end && !push.v1)
	`CED_ASSERT_NEXT(a_err_drop, clk, arst_n,
		push.v0 && push.r0.status != ST_OK && !in_final, st_q.mode == M_DROP)

endmodule

// ===== test/c_escape_sequence_decoder_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_core_tb
// Self-checking bench for the streaming C escape decoder. A short table of
// directed bytes covers the extremes, every error code and the escape forms.
// It is followed by random strings of plain bytes and well-formed escapes,
// with some noise mixed in. Both channels idle at random. Every result is
// compared field by field against the table's hand-written result or a
// cycle-free decoder model kept in the bench.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder_core_tb;
	import ced_pkg::*;

	localparam int          ITEM_TARGET = 900;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int          DRAIN_CYCLES = 8;

	localparam logic [7:0] SIMPLE_ESC [11] = '{8'h61, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74,
		8'h76, 8'h5c, 8'h27, 8'h22, 8'h3f};

	// one directed byte, with a hand-written result where it is obvious
	typedef struct packed {
		logic [7:0] c;
		logic       fin;
		logic       typed;
		logic [7:0] ch;
		status_t    st;
		logic       send;
	} plan_row_t;

	localparam int PLAN_LEN = 26;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{8'h41, 1'b0, 1'b1, 8'h41, ST_OK, 1'b0},
		'{8'h00, 1'b0, 1'b1, 8'h00, ST_OK, 1'b0},
		'{8'hff, 1'b1, 1'b1, 8'hff, ST_OK, 1'b1},
		'{8'h5c, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h6e, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h5c, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h78, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h46, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h66, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h7a, 1'b1, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h5c, 1'b1, 1'b1, 8'h00, ST_UNTERM, 1'b1},
		'{8'h5c, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h58, 1'b1, 1'b1, 8'h00, ST_NOHEX, 1'b1},
		'{8'h5c, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h78, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h67, 1'b1, 1'b1, 8'h00, ST_NOHEX, 1'b1},
		'{8'h5c, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h78, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h31, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h32, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h33, 1'b1, 1'b1, 8'h00, ST_HEXBIG, 1'b1},
		'{8'h5c, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h71, 1'b0, 1'b1, 8'h00, ST_UNKNOWN, 1'b1},
		'{8'h61, 1'b1, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h5c, 1'b0, 1'b0, 8'h00, ST_OK, 1'b0},
		'{8'h37, 1'b1, 1'b0, 8'h00, ST_OK, 1'b0}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_char = 8'h00;
	logic       in_final = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic [2:0] status;
	logic       run_end;
	logic       string_end;

	// decoder model state
	mode_t      dec_mode = M_IDLE;
	logic [7:0] dec_val = 8'h00;
	logic [1:0] dec_cnt = 2'd0;
	logic       dec_ovf = 1'b0;
	res_t       step_res [2];
	int         step_n;

	res_t       decoded_q [$];
	logic       pinned_on = 1'b0;
	res_t       pinned_res;
	int         useful_bytes = 0;
	int         errors = 0;
	int unsigned cycle_count = 0;
	logic       calm = 1'b0;
	logic       out_taken = 1'b1;
	int         stall_left = 0;

	c_escape_sequence_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_char(in_char),
		.in_final(in_final),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.status(status),
		.run_end(run_end),
		.string_end(string_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model

	function automatic int hex_val(input logic [7:0] c);
		logic [7:0] lc;
		lc = c | CASE_BIT;
		if (c >= 8'h30 && c <= 8'h39) return int'(c - CH_ZERO);
		if (lc >= 8'h61 && lc <= 8'h66) return int'(lc - 8'h61) + 10;
		return -1;
	endfunction

	function automatic int simple_val(input logic [7:0] c);
		case (c)
			8'h61: return 8'h07;
			8'h62: return 8'h08;
			8'h66: return 8'h0c;
			8'h6e: return 8'h0a;
			8'h72: return 8'h0d;
			8'h74: return 8'h09;
			8'h76: return 8'h0b;
			8'h5c, 8'h27, 8'h22, 8'h3f: return int'(c);
			default: return -1;
		endcase
	endfunction

	function automatic void emit(input logic [7:0] ch, input status_t st, input logic send);
		step_res[step_n] = '{ch: ch, status: st, run_end: 1'b0, string_end: send};
		step_n++;
	endfunction

	function automatic void clear_to(input mode_t m);
		dec_mode = m;
		dec_val = 8'h00;
		dec_cnt = 2'd0;
		dec_ovf = 1'b0;
	endfunction

	// an error closes the string; without the final byte the rest is dropped
	function automatic void raise_error(input status_t st, input logic fin);
		clear_to(fin ? M_IDLE : M_DROP);
		emit(8'h00, st, 1'b1);
	endfunction

	function automatic void take_plain(input logic [7:0] c, input logic fin);
		if (c == CH_BSLASH) begin
			if (fin) raise_error(ST_UNTERM, 1'b1);
			else clear_to(M_ESC);
		end else begin
			clear_to(M_IDLE);
			emit(c, ST_OK, fin);
		end
	endfunction

	// advance the model by one byte; results land in step_res[0 .. step_n-1]
	function automatic void decode_byte(input logic [7:0] c, input logic fin);
		int         d;
		logic [7:0] v;
		step_n = 0;
		case (dec_mode)
			M_ESC: begin
				d = simple_val(c);
				if (d >= 0) begin
					clear_to(M_IDLE);
					emit(8'(d), ST_OK, fin);
				end else if (c == CH_X_LO || c == CH_X_UP) begin
					if (fin) raise_error(ST_NOHEX, 1'b1);
					else clear_to(M_HEX_FIRST);
				end else if (c >= 8'h30 && c <= 8'h37) begin
					if (fin) begin
						clear_to(M_IDLE);
						emit({5'd0, c[2:0]}, ST_OK, 1'b1);
					end else begin
						clear_to(M_OCT);
						dec_val = {5'd0, c[2:0]};
						dec_cnt = 2'd1;
					end
				end else begin
					raise_error(ST_UNKNOWN, fin);
				end
			end
			M_HEX_FIRST: begin
				d = hex_val(c);
				if (d < 0) begin
					raise_error(ST_NOHEX, fin);
				end else if (fin) begin
					clear_to(M_IDLE);
					emit(8'(d), ST_OK, 1'b1);
				end else begin
					clear_to(M_HEX);
					dec_val = 8'(d);
				end
			end
			M_HEX: begin
				d = hex_val(c);
				if (d >= 0) begin
					// any set bit shifted out of the byte sticks as overflow
					if (dec_val > 8'h0f) dec_ovf = 1'b1;
					dec_val = {dec_val[3:0], 4'(d)};
					if (fin) begin
						if (dec_ovf) begin
							raise_error(ST_HEXBIG, 1'b1);
						end else begin
							v = dec_val;
							clear_to(M_IDLE);
							emit(v, ST_OK, 1'b1);
						end
					end
				end else if (dec_ovf) begin
					raise_error(ST_HEXBIG, fin);
				end else begin
					emit(dec_val, ST_OK, 1'b0);
					take_plain(c, fin);
				end
			end
			M_OCT: begin
				if (c >= 8'h30 && c <= 8'h37 && dec_cnt < 2'd3) begin
					dec_val = {dec_val[4:0], c[2:0]};
					dec_cnt = dec_cnt + 2'd1;
					if (dec_cnt == 2'd3 || fin) begin
						v = dec_val;
						clear_to(M_IDLE);
						emit(v, ST_OK, fin);
					end
				end else begin
					emit(dec_val, ST_OK, 1'b0);
					take_plain(c, fin);
				end
			end
			M_DROP: begin
				if (fin) clear_to(M_IDLE);
			end
			default: begin
				take_plain(c, fin);
			end
		endcase
		if (step_n > 0) step_res[step_n - 1].run_end = 1'b1;
	endfunction

	// ---------------------------------------------------------------- checking

	// predict on each input transfer, then check any output transfer
	always @(posedge clk) begin
		res_t want;
		if (arst_n && in_valid && !in_stall) begin
			if (dec_mode != M_DROP) useful_bytes++;
			decode_byte(in_char, in_final);
			if (pinned_on) begin
				decoded_q.push_back(pinned_res);
			end else begin
				for (int i = 0; i < step_n; i++) decoded_q.push_back(step_res[i]);
			end
		end
		if (arst_n && out_valid && !out_stall) begin
			out_taken = 1'b1;
			if (decoded_q.size() == 0) begin
				$error("unexpected result: out_char %h status %0d", out_char, status);
				errors++;
			end else begin
				want = decoded_q.pop_front();
				if (out_char !== want.ch) begin
					$error("out_char: expected %h, got %h", want.ch, out_char);
					errors++;
				end
				if (status !== 3'(want.status)) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (run_end !== want.run_end) begin
					$error("run_end: expected %b, got %b", want.run_end, run_end);
					errors++;
				end
				if (string_end !== want.string_end) begin
					$error("string_end: expected %b, got %b", want.string_end, string_end);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// draw a fresh stall length after every output transfer
	always @(negedge clk) begin
		if (out_taken) begin
			out_taken = 1'b0;
			stall_left = calm ? 0 : $urandom_range(0, 6);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// hard stop
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sender

	// hold a byte after a random gap until its transfer, return at the next fall
	task automatic put_byte(input logic [7:0] c, input logic fin);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_char <= c;
		in_final <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] hex_char(input int idx);
		if (idx < 10) return CH_ZERO + 8'(idx);
		if (idx < 16) return 8'h61 + 8'(idx - 10);
		return 8'h41 + 8'(idx - 16);
	endfunction

	initial begin
		logic [7:0] text_q [$];
		int         kind;
		int         n;
		int         k;
		logic [7:0] c;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (int r = 0; r < PLAN_LEN; r++) begin
			pinned_on = PLAN[r].typed;
			pinned_res = '{ch: PLAN[r].ch, status: PLAN[r].st, run_end: 1'b1,
				string_end: PLAN[r].send};
			put_byte(PLAN[r].c, PLAN[r].fin);
		end
		pinned_on = 1'b0;

		// random strings, built from plain bytes and well-formed escapes
		while (useful_bytes < ITEM_TARGET) begin
			if ($urandom_range(0, 15) == 0) calm = ($urandom_range(0, 2) == 0);
			text_q.delete();
			if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					kind = $urandom_range(0, 99);
					if (kind < 40) begin
						c = 8'($urandom_range(0, 255));
						if (c == CH_BSLASH) c = c ^ 8'h01;
						text_q.push_back(c);
					end else if (kind < 55) begin
						text_q.push_back(CH_BSLASH);
						text_q.push_back(SIMPLE_ESC[$urandom_range(0, 10)]);
					end else if (kind < 70) begin
						text_q.push_back(CH_BSLASH);
						k = $urandom_range(1, 3);
						for (int j = 0; j < k; j++)
							text_q.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
					end else if (kind < 85) begin
						text_q.push_back(CH_BSLASH);
						text_q.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
						k = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 6)
							: $urandom_range(1, 2);
						for (int j = 0; j < k; j++)
							text_q.push_back(hex_char($urandom_range(0, 21)));
					end else if (kind < 92) begin
						// unknown escape or x without a digit
						text_q.push_back(CH_BSLASH);
						if ($urandom_range(0, 1)) text_q.push_back(CH_X_LO);
						text_q.push_back(8'($urandom_range(0, 255)));
					end else begin
						text_q.push_back(8'($urandom_range(0, 255)));
					end
				end
			end
			if ($urandom_range(0, 29) == 0) text_q.push_back(CH_BSLASH);
			for (int i = 0; i < text_q.size(); i++)
				put_byte(text_q[i], i == text_q.size() - 1);
		end
		in_valid <= 1'b0;

		// drain, then watch for stray results
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
